@@ hdl/mriu_pkg.sv @@
`timescale 1ns / 1ps
package mriu_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int COORD_BITS  = 8;
  localparam int SIZE_BITS   = COORD_BITS + 1;
  localparam int IDX_BITS    = 32;
  localparam int STEP_BITS   = 33;
  localparam int CMP_BITS    = STEP_BITS + COORD_BITS;
  localparam int DIMS_BITS   = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 9;
  localparam int PREP_STAGES = MAX_DIMS;
  localparam int NUM_CELLS   = MAX_DIMS * COORD_BITS;

  typedef enum logic [1:0] {
    OP_FLAT  = 2'd0,
    OP_SPLIT = 2'd1,
    OP_INC   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_DIMS = 3'd0,
    CFG_SIZE_0   = 3'd1,
    CFG_SIZE_1   = 3'd2,
    CFG_SIZE_2   = 3'd3,
    CFG_SIZE_3   = 3'd4
  } cfg_idx_t;

  typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] coords_t;
  typedef logic [MAX_DIMS-1:0][SIZE_BITS-1:0]  sizes_t;
  typedef logic [MAX_DIMS-1:0][STEP_BITS-1:0]  steps_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          op;
    logic [IDX_BITS-1:0] idx;
    coords_t             coord;
  } raw_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          op;
    logic                err;
    logic                carry;
    logic [IDX_BITS-1:0] rem;
    logic [IDX_BITS-1:0] acc;
    coords_t             coord;
  } item_t;

  function automatic logic [DIMS_BITS-1:0] used_dims(input logic [DIMS_BITS-1:0] v);
    logic [DIMS_BITS-1:0] r;
    r = v;
    if (v == '0) r = DIMS_BITS'(1);
    else if (int'(v) > MAX_DIMS) r = DIMS_BITS'(MAX_DIMS);
    return r;
  endfunction

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] r;
    r = s;
    if (s == '0) r = SIZE_BITS'(1);
    else if (s > (SIZE_BITS'(1) << COORD_BITS)) r = SIZE_BITS'(1) << COORD_BITS;
    return r;
  endfunction

endpackage

@@ hdl/mixed_radix_index_unit_core.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle; busy stays low, a new item may follow every cycle.
// The chain holds one cell per coordinate bit, each one shift-and-add or compare-subtract.
// After a size write the registered step products settle, covered by the input delay.
// Reset: synchronous, active high; sizes return to 256, num_dims to 4, pipeline empties.
// The receiver cannot stall: each result shows for one cycle with done high.
module mixed_radix_index_unit_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          operation,
  input  logic [mriu_pkg::IDX_BITS-1:0]       flat_index,
  input  logic [mriu_pkg::COORD_BITS-1:0]     coord_in_0,
  input  logic [mriu_pkg::COORD_BITS-1:0]     coord_in_1,
  input  logic [mriu_pkg::COORD_BITS-1:0]     coord_in_2,
  input  logic [mriu_pkg::COORD_BITS-1:0]     coord_in_3,
  input  logic                                cfg_write,
  input  logic [mriu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mriu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                done,
  output logic [mriu_pkg::IDX_BITS-1:0]       flat_index_out,
  output logic [mriu_pkg::COORD_BITS-1:0]     coord_out_0,
  output logic [mriu_pkg::COORD_BITS-1:0]     coord_out_1,
  output logic [mriu_pkg::COORD_BITS-1:0]     coord_out_2,
  output logic [mriu_pkg::COORD_BITS-1:0]     coord_out_3,
  output logic                                carry_out,
  output logic                                range_error
);
  import mriu_pkg::*;

  logic [DIMS_BITS-1:0] num_dims;
  sizes_t               sizes;
  steps_t               steps;
  logic [STEP_BITS-1:0] total;
  logic [DIMS_BITS-1:0] n;
  logic [MAX_DIMS-1:0]  use_dim;
  raw_t                 raw_in;
  raw_t                 prep [PREP_STAGES];
  item_t                link [NUM_CELLS+1];
  item_t                last;
  coords_t              coord_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= DIMS_BITS'(4);
      for (int d = 0; d < MAX_DIMS; d++) sizes[d] <= SIZE_BITS'(256);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_DIMS: num_dims <= cfg_data[DIMS_BITS-1:0];
        CFG_SIZE_0:   sizes[0] <= cfg_data[SIZE_BITS-1:0];
        CFG_SIZE_1:   sizes[1] <= cfg_data[SIZE_BITS-1:0];
        CFG_SIZE_2:   sizes[2] <= cfg_data[SIZE_BITS-1:0];
        CFG_SIZE_3:   sizes[3] <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_in.valid = start && !busy;
    raw_in.op    = operation;
    raw_in.idx   = flat_index;
    raw_in.coord = {coord_in_3, coord_in_2, coord_in_1, coord_in_0};
    n = used_dims(num_dims);
    for (int d = 0; d < MAX_DIMS; d++) use_dim[d] = (d < int'(n));
  end

  always_ff @(posedge clk) begin
    prep[0] <= raw_in;
    for (int k = 1; k < PREP_STAGES; k++) prep[k] <= prep[k-1];
    if (rst) begin
      for (int k = 0; k < PREP_STAGES; k++) prep[k].valid <= 1'b0;
    end
  end

  mriu_steps u_steps (
    .clk      (clk),
    .num_dims (num_dims),
    .sizes    (sizes),
    .steps    (steps),
    .total    (total)
  );

  mriu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .raw      (prep[PREP_STAGES-1]),
    .num_dims (num_dims),
    .sizes    (sizes),
    .total    (total),
    .item     (link[0])
  );

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    for (genvar b = 0; b < COORD_BITS; b++) begin : g_bit
      localparam int K = d * COORD_BITS + (COORD_BITS - 1 - b);
      mriu_cell #(
        .DIM (d),
        .BIT (b)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .d_in    (link[K]),
        .step    (steps[d]),
        .use_dim (use_dim[d]),
        .d_out   (link[K+1])
      );
    end
  end

  assign last = link[NUM_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    flat_index_out <= (op_t'(last.op) == OP_FLAT && !last.err) ? last.acc : '0;
    coord_q        <= last.err ? '0 : last.coord;
    carry_out      <= last.carry;
    range_error    <= last.err;
  end

  assign coord_out_0 = coord_q[0];
  assign coord_out_1 = coord_q[1];
  assign coord_out_2 = coord_q[2];
  assign coord_out_3 = coord_q[3];

endmodule

@@ hdl/mriu_steps.sv @@
`timescale 1ns / 1ps
module mriu_steps (
  input  logic                            clk,
  input  logic [mriu_pkg::DIMS_BITS-1:0]  num_dims,
  input  mriu_pkg::sizes_t                sizes,
  output mriu_pkg::steps_t                steps,
  output logic [mriu_pkg::STEP_BITS-1:0]  total
);
  import mriu_pkg::*;

  localparam int PW = STEP_BITS + SIZE_BITS;

  logic [DIMS_BITS-1:0] n;
  sizes_t               sp;
  steps_t               step_q;
  logic [PW-1:0]        prod [MAX_DIMS];
  logic [STEP_BITS-1:0] total_q;

  always_comb begin
    n = used_dims(num_dims);
    for (int d = 0; d < MAX_DIMS; d++) begin
      sp[d] = (d < int'(n)) ? eff_size(sizes[d]) : SIZE_BITS'(1);
      prod[d] = PW'(step_q[d]) * PW'(sp[d]);
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < MAX_DIMS - 1; d++) begin
      step_q[d] <= STEP_BITS'(prod[d+1]);
    end
    step_q[MAX_DIMS-1] <= STEP_BITS'(1);
    total_q <= STEP_BITS'(prod[0]);
  end

  assign steps = step_q;
  assign total = total_q;

endmodule

@@ hdl/mriu_front.sv @@
`timescale 1ns / 1ps
module mriu_front (
  input  logic                            clk,
  input  logic                            rst,
  input  mriu_pkg::raw_t                  raw,
  input  logic [mriu_pkg::DIMS_BITS-1:0]  num_dims,
  input  mriu_pkg::sizes_t                sizes,
  input  logic [mriu_pkg::STEP_BITS-1:0]  total,
  output mriu_pkg::item_t                 item
);
  import mriu_pkg::*;

  logic [DIMS_BITS-1:0] n;
  sizes_t               s;
  coords_t              c;
  coords_t              ci;
  logic [SIZE_BITS-1:0] nxt;
  logic                 err;
  logic                 carry;
  item_t                item_next;
  item_t                item_q;

  always_comb begin
    n = used_dims(num_dims);
    err = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      s[d] = eff_size(sizes[d]);
      c[d] = (d < int'(n)) ? raw.coord[d] : '0;
      if ((d < int'(n)) && ({1'b0, c[d]} >= s[d])) err = 1'b1;
    end
    unique case (op_t'(raw.op))
      OP_FLAT:  ;
      OP_INC:   ;
      OP_SPLIT: err = ({1'b0, raw.idx} >= total);
      default:  err = 1'b1;
    endcase
    carry = 1'b1;
    ci = c;
    nxt = '0;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      if ((d < int'(n)) && carry) begin
        nxt = {1'b0, ci[d]} + SIZE_BITS'(1);
        if (nxt == s[d]) begin
          ci[d] = '0;
        end else begin
          ci[d] = nxt[COORD_BITS-1:0];
          carry = 1'b0;
        end
      end
    end
    item_next.valid = raw.valid;
    item_next.op    = raw.op;
    item_next.err   = err;
    item_next.carry = (op_t'(raw.op) == OP_INC) && !err && carry;
    item_next.rem   = raw.idx;
    item_next.acc   = '0;
    if (err || (op_t'(raw.op) == OP_SPLIT)) item_next.coord = '0;
    else if (op_t'(raw.op) == OP_INC) item_next.coord = ci;
    else item_next.coord = c;
  end

  always_ff @(posedge clk) begin
    item_q <= item_next;
    if (rst) item_q.valid <= 1'b0;
  end

  assign item = item_q;

endmodule

@@ hdl/mriu_cell.sv @@
`timescale 1ns / 1ps
module mriu_cell #(
  parameter int DIM = 0,
  parameter int BIT = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mriu_pkg::item_t                 d_in,
  input  logic [mriu_pkg::STEP_BITS-1:0]  step,
  input  logic                            use_dim,
  output mriu_pkg::item_t                 d_out
);
  import mriu_pkg::*;

  logic [CMP_BITS-1:0] shifted;
  item_t               nxt;
  item_t               q;

  always_comb begin
    shifted = CMP_BITS'(step) << BIT;
    nxt = d_in;
    if (d_in.valid && !d_in.err && use_dim) begin
      unique case (op_t'(d_in.op))
        OP_SPLIT: begin
          if (CMP_BITS'(d_in.rem) >= shifted) begin
            nxt.rem = d_in.rem - shifted[IDX_BITS-1:0];
            nxt.coord[DIM][BIT] = 1'b1;
          end
        end
        OP_FLAT: begin
          if (d_in.coord[DIM][BIT]) nxt.acc = d_in.acc + shifted[IDX_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    q <= nxt;
    if (rst) q.valid <= 1'b0;
  end

  assign d_out = q;

endmodule
